// ===== sv/llqd_pkg.sv =====
// Shared types and constants for the least-loaded queue dispatcher.
// No dependencies; llqd_queue_ctrl, the top and the checker import this package.
package llqd_pkg;

   localparam int NUM_QUEUES          = 3;
   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int ID_W                = 16;
   localparam int WEIGHT_W            = 16;
   localparam int ENTRY_W             = ID_W + WEIGHT_W;
   localparam int LINE_W              = 2;
   localparam int KIND_W              = 2;

   // operation codes
   localparam logic OP_JOIN     = 1'b0;
   localparam logic OP_CHECKOUT = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_JOIN   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEPART = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

   // queue numbers
   localparam logic [LINE_W-1:0] LINE_0 = 2'd0;
   localparam logic [LINE_W-1:0] LINE_1 = 2'd1;
   localparam logic [LINE_W-1:0] LINE_2 = 2'd2;

   typedef struct packed {
      logic                operation;
      logic [ID_W-1:0]     customer_id;
      logic [WEIGHT_W-1:0] item_count;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]   result_kind;
      logic [LINE_W-1:0]   line_number;
      logic [ID_W-1:0]     customer_id_out;
      logic [WEIGHT_W-1:0] item_count_out;
      logic                rejected;
      logic                last_result;
   } rsp_type;

   // update requests to the queue bookkeeping
   typedef struct packed {
      logic                push;
      logic [LINE_W-1:0]   push_q;
      logic [WEIGHT_W-1:0] push_w;
      logic                pop;
      logic [LINE_W-1:0]   pop_q;
      logic                sub;
      logic [LINE_W-1:0]   sub_q;
      logic [WEIGHT_W-1:0] sub_w;
   } qop_type;

endpackage

// ===== sv/llqd_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module llqd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 48,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/llqd_queue_ctrl.sv =====
// Per-queue bookkeeping: head and tail slots, occupancy and load totals,
// plus the least-loaded queue pick and non-empty mask. Depends on llqd_pkg.
module llqd_queue_ctrl #(
   parameter int QUEUE_DEPTH = llqd_pkg::QUEUE_DEPTH_DEFAULT,
   localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  llqd_pkg::qop_type            qop,
   output logic [IDX_W-1:0]             head_idx [llqd_pkg::NUM_QUEUES],
   output logic [IDX_W-1:0]             tail_idx [llqd_pkg::NUM_QUEUES],
   output logic [llqd_pkg::LINE_W-1:0]  pick_q,
   output logic                         pick_full,
   output logic [llqd_pkg::NUM_QUEUES-1:0] nonempty
);
   import llqd_pkg::*;

   localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int LOAD_W = WEIGHT_W + OCC_W;

   logic [IDX_W-1:0]  head_ff [NUM_QUEUES];
   logic [IDX_W-1:0]  head_in [NUM_QUEUES];
   logic [IDX_W-1:0]  tail_ff [NUM_QUEUES];
   logic [IDX_W-1:0]  tail_in [NUM_QUEUES];
   logic [OCC_W-1:0]  occ_ff  [NUM_QUEUES];
   logic [OCC_W-1:0]  occ_in  [NUM_QUEUES];
   logic [LOAD_W-1:0] load_ff [NUM_QUEUES];
   logic [LOAD_W-1:0] load_in [NUM_QUEUES];
   logic [LOAD_W-1:0] sub_w_ext;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
      if (idx == IDX_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return idx + IDX_W'(1);
   endfunction

   assign sub_w_ext = LOAD_W'(qop.sub_w);

   always_comb begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
         head_in[i] = head_ff[i];
         tail_in[i] = tail_ff[i];
         occ_in[i]  = occ_ff[i];
         load_in[i] = load_ff[i];
         // push and pop never target the same queue in one cycle
         if (qop.push && qop.push_q == LINE_W'(i)) begin
            tail_in[i] = wrap_inc(tail_ff[i]);
            occ_in[i]  = occ_ff[i] + OCC_W'(1);
            load_in[i] = load_ff[i] + LOAD_W'(qop.push_w);
         end
         if (qop.pop && qop.pop_q == LINE_W'(i)) begin
            head_in[i] = wrap_inc(head_ff[i]);
            occ_in[i]  = occ_ff[i] - OCC_W'(1);
         end
         if (qop.sub && qop.sub_q == LINE_W'(i)) begin
            load_in[i] = (load_ff[i] >= sub_w_ext) ? load_ff[i] - sub_w_ext : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
            occ_ff[i]  <= '0;
            load_ff[i] <= '0;
         end
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
         load_ff <= load_in;
      end
   end

   // ties favour the lower queue number
   always_comb begin
      priority if (load_ff[0] <= load_ff[1] && load_ff[0] <= load_ff[2]) begin
         pick_q = LINE_0;
      end else if (load_ff[1] <= load_ff[2]) begin
         pick_q = LINE_1;
      end else begin
         pick_q = LINE_2;
      end
   end

   assign pick_full = (occ_ff[pick_q] == OCC_W'(QUEUE_DEPTH));

   always_comb begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
         nonempty[i] = (occ_ff[i] != '0);
      end
   end

   assign head_idx = head_ff;
   assign tail_idx = tail_ff;

endmodule

// ===== sv/least_loaded_queue_dispatch_top.sv =====
// Least-loaded queue dispatcher: three job FIFOs sharing one job RAM.
// Depends on llqd_pkg, llqd_ram and llqd_queue_ctrl.
//
// Usage
//   A transaction is taken when start is high and busy is low. A join
//   (operation 0) goes to the queue with the smallest load total, ties to
//   the lower queue; a full queue rejects the job. A checkout (operation 1)
//   removes the head job of every non-empty queue in queue order.
//   Results appear on rsp_item for one cycle, flagged by rsp_strobe; the
//   last result of a transaction has last_result set.
// Timing and throughput
//   Join: result in the cycle after acceptance; busy stays low, so a join
//   can be taken every cycle. Checkout: the state turns to drain, a head
//   read of the job RAM is issued, the first departure is registered from
//   its data, the rest one per cycle; busy is high while the queues drain.
//   An all-empty checkout answers in the cycle after acceptance without
//   raising busy. The single job RAM read port sets the checkout rate.
// Reset clears all queues at once; the job RAM needs no clearing.
// The receiver cannot stall: every strobed result is taken as shown.
module least_loaded_queue_dispatch_top #(
   parameter int QUEUE_DEPTH = llqd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  llqd_pkg::req_type req_item,
   output logic              rsp_strobe,
   output llqd_pkg::rsp_type rsp_item
);
   import llqd_pkg::*;

   localparam int IDX_W    = $clog2(QUEUE_DEPTH);
   localparam int RAM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
   localparam int ADDR_W   = $clog2(RAM_DEPTH);

   typedef enum logic {ST_IDLE, ST_DRAIN} state_type;

   state_type               state_ff, state_in;
   logic [NUM_QUEUES-1:0]   mask_ff, mask_in, mask_rest;
   logic                    pend_valid_ff, pend_valid_in;
   logic [LINE_W-1:0]       pend_q_ff, pend_q_in;
   logic                    pend_last_ff, pend_last_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   qop_type                 qop;
   logic [IDX_W-1:0]        head_idx [NUM_QUEUES];
   logic [IDX_W-1:0]        tail_idx [NUM_QUEUES];
   logic [LINE_W-1:0]       pick_q;
   logic                    pick_full;
   logic [NUM_QUEUES-1:0]   nonempty;

   logic                    accept;
   logic [LINE_W-1:0]       sel_q;
   logic                    ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]       ram_wr_addr, ram_rd_addr;
   logic [ENTRY_W-1:0]      ram_wr_data, ram_rd_data;

   llqd_queue_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_qctrl (
      .clock     (clock),
      .reset     (reset),
      .qop       (qop),
      .head_idx  (head_idx),
      .tail_idx  (tail_idx),
      .pick_q    (pick_q),
      .pick_full (pick_full),
      .nonempty  (nonempty)
   );

   llqd_ram #(.WIDTH(ENTRY_W), .DEPTH(RAM_DEPTH)) u_job_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   function automatic logic [ADDR_W-1:0] slot_addr(input logic [LINE_W-1:0] q,
                                                   input logic [IDX_W-1:0]  slot);
      return ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
   endfunction

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // lowest queue still to be drained
   always_comb begin
      mask_rest = mask_ff;
      priority if (mask_ff[0]) begin
         sel_q        = LINE_0;
         mask_rest[0] = 1'b0;
      end else if (mask_ff[1]) begin
         sel_q        = LINE_1;
         mask_rest[1] = 1'b0;
      end else begin
         sel_q        = LINE_2;
         mask_rest[2] = 1'b0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      mask_in       = mask_ff;
      pend_valid_in = 1'b0;
      pend_q_in     = pend_q_ff;
      pend_last_in  = pend_last_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      qop           = '0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = slot_addr(pick_q, tail_idx[pick_q]);
      ram_wr_data   = {req_item.item_count, req_item.customer_id};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = slot_addr(sel_q, head_idx[sel_q]);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.operation == OP_JOIN) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{result_kind:     KIND_JOIN,
                                   line_number:     pick_q,
                                   customer_id_out: req_item.customer_id,
                                   item_count_out:  req_item.item_count,
                                   rejected:        pick_full,
                                   last_result:     1'b1};
                  if (!pick_full) begin
                     ram_wr_en   = 1'b1;
                     qop.push    = 1'b1;
                     qop.push_q  = pick_q;
                     qop.push_w  = req_item.item_count;
                  end
               end else if (nonempty == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{result_kind:     KIND_EMPTY,
                                   line_number:     LINE_0,
                                   customer_id_out: '0,
                                   item_count_out:  '0,
                                   rejected:        1'b0,
                                   last_result:     1'b1};
               end else begin
                  mask_in  = nonempty;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // head read issued last cycle: report it and settle the load
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{result_kind:     KIND_DEPART,
                                line_number:     pend_q_ff,
                                customer_id_out: ram_rd_data[ID_W-1:0],
                                item_count_out:  ram_rd_data[ENTRY_W-1:ID_W],
                                rejected:        1'b0,
                                last_result:     pend_last_ff};
               qop.sub      = 1'b1;
               qop.sub_q    = pend_q_ff;
               qop.sub_w    = ram_rd_data[ENTRY_W-1:ID_W];
            end
            if (mask_ff != '0) begin
               ram_rd_en     = 1'b1;
               qop.pop       = 1'b1;
               qop.pop_q     = sel_q;
               pend_valid_in = 1'b1;
               pend_q_in     = sel_q;
               pend_last_in  = (mask_rest == '0);
               mask_in       = mask_rest;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mask_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mask_ff       <= mask_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_q_ff    <= pend_q_in;
      pend_last_ff <= pend_last_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

// ===== sv/llqd_checker.sv =====
// Port-level checks for the least-loaded queue dispatcher, bound to the top.
// Depends on llqd_pkg and least_loaded_queue_dispatch_top.
module llqd_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input llqd_pkg::req_type req_item,
   input logic              rsp_strobe,
   input llqd_pkg::rsp_type rsp_item
);
   import llqd_pkg::*;

   // a join is answered in the very next cycle, as its only result
   a_join_answer: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.operation == OP_JOIN
      |=> rsp_strobe && rsp_item.last_result && rsp_item.result_kind == KIND_JOIN)
      else $error("join transaction not answered in the next cycle");

   // departures of one checkout come back to back
   a_depart_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last_result
      |=> rsp_strobe && rsp_item.result_kind == KIND_DEPART)
      else $error("gap inside a checkout burst");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.result_kind == KIND_EMPTY
      |-> rsp_item.last_result && rsp_item.line_number == LINE_0 &&
          rsp_item.customer_id_out == '0 && rsp_item.item_count_out == '0)
      else $error("empty checkout result carries data");

   a_reject_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.rejected |-> rsp_item.result_kind == KIND_JOIN)
      else $error("rejection flagged on a non-join result");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("activity right after reset");

endmodule

bind least_loaded_queue_dispatch_top llqd_checker u_llqd_checker (.*);
